FILE: src/lr_pkg.sv
// Shared types, constants and step functions for the line rasterizer.
package lr_pkg;

  localparam int MAX_SCREEN_DIM = 2048;
  localparam int COORD_W        = 11;
  localparam int IN_COORD_W     = 13;
  localparam int LIM_W          = 12;
  localparam int DEC_W          = 14;
  localparam int COLOR_W        = 32;
  localparam int CFG_ADDR_W     = 2;
  localparam int IN_DATA_W      = 120;
  localparam int OUT_DATA_W     = 56;
  localparam int OUT_USER_W     = 2;

  localparam logic ACT_START = 1'b0;
  localparam logic ACT_STEP  = 1'b1;

  localparam logic [CFG_ADDR_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_SCREEN_HEIGHT = 2'd1;

  typedef logic [COORD_W-1:0]         coord_t;
  typedef logic [COLOR_W-1:0]         color_t;
  typedef logic signed [DEC_W-1:0]    dec_t;
  typedef logic signed [IN_COORD_W-1:0] in_coord_t;
  typedef logic [LIM_W-1:0]           lim_t;

  typedef struct packed {
    logic   action;
    logic   reject;
    logic   steep;
    logic   rows_fall;
    coord_t x0;
    coord_t y0;
    coord_t x1;
    coord_t y1;
    coord_t major;
    coord_t minor;
    dec_t   decision;
    color_t c0;
    color_t c1;
  } item_t;

  typedef struct packed {
    logic   busy;
    coord_t cur_col;
    coord_t cur_row;
    coord_t stop_col;
    coord_t stop_row;
    dec_t   decision;
    coord_t major_delta;
    coord_t minor_delta;
    logic   steep;
    logic   rows_fall;
    color_t body_color;
    color_t final_color;
  } line_t;

  typedef struct packed {
    logic   pixel_valid;
    coord_t pixel_x;
    coord_t pixel_y;
    color_t pixel_color;
    logic   last_pixel;
    logic   rejected;
  } res_t;

  function automatic logic line_at_stop(input line_t s);
    return s.steep ? (s.cur_row == s.stop_row) : (s.cur_col == s.stop_col);
  endfunction

  // One Bresenham step along the major axis, with the minor move decided first.
  function automatic line_t line_advance(input line_t s);
    line_t  n;
    logic   gt;
    dec_t   d;
    coord_t row_step;
    n = s;
    if (!line_at_stop(s)) begin
      gt = (s.decision > 0);
      d  = s.decision + $signed({2'b00, s.minor_delta, 1'b0});
      if (gt) begin
        d = d - $signed({2'b00, s.major_delta, 1'b0});
      end
      row_step = s.rows_fall ? (s.cur_row - coord_t'(1)) : (s.cur_row + coord_t'(1));
      n.decision = d;
      if (s.steep) begin
        n.cur_row = row_step;
        if (gt) begin
          n.cur_col = s.cur_col + coord_t'(1);
        end
      end else begin
        n.cur_col = s.cur_col + coord_t'(1);
        if (gt) begin
          n.cur_row = row_step;
        end
      end
    end
    return n;
  endfunction

endpackage

FILE: src/lr_prep.sv
// Input register stage: screen registers, endpoint ordering, off-screen rejection and line setup.
module lr_prep (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [lr_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [lr_pkg::LIM_W-1:0]      cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          action,
  input  lr_pkg::in_coord_t             start_x,
  input  lr_pkg::in_coord_t             start_y,
  input  lr_pkg::in_coord_t             end_x,
  input  lr_pkg::in_coord_t             end_y,
  input  lr_pkg::color_t                start_color,
  input  lr_pkg::color_t                end_color,
  output logic                          item_valid,
  output lr_pkg::item_t                 item,
  input  logic                          core_ready
);

  localparam lr_pkg::lim_t LIM_MAX = lr_pkg::LIM_W'(lr_pkg::MAX_SCREEN_DIM);

  lr_pkg::lim_t  width_r;
  lr_pkg::lim_t  height_r;
  lr_pkg::item_t prep_r;
  lr_pkg::item_t prep_nxt;
  logic          prep_valid_r;

  lr_pkg::lim_t      w_eff;
  lr_pkg::lim_t      h_eff;
  logic              swap;
  lr_pkg::in_coord_t x0;
  lr_pkg::in_coord_t y0;
  lr_pkg::in_coord_t x1;
  lr_pkg::in_coord_t y1;
  lr_pkg::coord_t    dx;
  logic signed [lr_pkg::COORD_W:0] dy;
  logic signed [lr_pkg::COORD_W:0] dy_neg;
  lr_pkg::coord_t    ady;
  logic              steep;

  function automatic logic off_screen(input lr_pkg::in_coord_t v, input lr_pkg::lim_t lim);
    return v[lr_pkg::IN_COORD_W-1] || (v[lr_pkg::IN_COORD_W-2:0] >= lim);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 12'd1024;
      height_r <= 12'd768;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        lr_pkg::REG_SCREEN_WIDTH:  width_r  <= cfg_wdata;
        lr_pkg::REG_SCREEN_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_ready = !prep_valid_r || core_ready;

  always_comb begin
    w_eff  = (width_r > LIM_MAX) ? LIM_MAX : width_r;
    h_eff  = (height_r > LIM_MAX) ? LIM_MAX : height_r;
    swap   = (end_x < start_x);
    x0     = swap ? end_x : start_x;
    y0     = swap ? end_y : start_y;
    x1     = swap ? start_x : end_x;
    y1     = swap ? start_y : end_y;
    dx     = x1[lr_pkg::COORD_W-1:0] - x0[lr_pkg::COORD_W-1:0];
    dy     = $signed({1'b0, y1[lr_pkg::COORD_W-1:0]}) - $signed({1'b0, y0[lr_pkg::COORD_W-1:0]});
    dy_neg = -dy;
    ady    = dy[lr_pkg::COORD_W] ? dy_neg[lr_pkg::COORD_W-1:0] : dy[lr_pkg::COORD_W-1:0];
    steep  = !(dx > ady);

    prep_nxt.action    = action;
    prep_nxt.reject    = off_screen(x0, w_eff) || off_screen(y0, h_eff) ||
                         off_screen(x1, w_eff) || off_screen(y1, h_eff);
    prep_nxt.steep     = steep;
    prep_nxt.rows_fall = dy[lr_pkg::COORD_W] || (dy == '0);
    prep_nxt.x0        = x0[lr_pkg::COORD_W-1:0];
    prep_nxt.y0        = y0[lr_pkg::COORD_W-1:0];
    prep_nxt.x1        = x1[lr_pkg::COORD_W-1:0];
    prep_nxt.y1        = y1[lr_pkg::COORD_W-1:0];
    prep_nxt.major     = steep ? ady : dx;
    prep_nxt.minor     = steep ? dx : ady;
    prep_nxt.decision  = $signed({2'b00, prep_nxt.minor, 1'b0}) -
                         $signed({3'b000, prep_nxt.major});
    prep_nxt.c0        = swap ? end_color : start_color;
    prep_nxt.c1        = swap ? start_color : end_color;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prep_valid_r <= 1'b0;
    end else if (in_ready) begin
      prep_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      prep_r <= prep_nxt;
    end
  end

  assign item_valid = prep_valid_r;
  assign item       = prep_r;

endmodule

FILE: src/lr_engine.sv
// Line state, per-item step logic and the result register.
module lr_engine (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          item_valid,
  input  lr_pkg::item_t item,
  output logic          core_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output lr_pkg::res_t  res
);

  lr_pkg::line_t line_r;
  lr_pkg::line_t line_nxt;
  lr_pkg::line_t loaded;
  lr_pkg::res_t  res_r;
  lr_pkg::res_t  res_nxt;
  logic          out_valid_r;
  logic          take;

  assign core_ready = !out_valid_r || out_ready;
  assign take       = item_valid && core_ready;

  always_comb begin
    loaded.busy        = 1'b1;
    loaded.cur_col     = item.x0;
    loaded.cur_row     = item.y0;
    loaded.stop_col    = item.x1;
    loaded.stop_row    = item.y1;
    loaded.decision    = item.decision;
    loaded.major_delta = item.major;
    loaded.minor_delta = item.minor;
    loaded.steep       = item.steep;
    loaded.rows_fall   = item.rows_fall;
    loaded.body_color  = item.c0;
    loaded.final_color = item.c1;

    line_nxt = line_r;
    res_nxt  = '0;
    if (item.action == lr_pkg::ACT_START) begin
      if (item.reject) begin
        line_nxt.busy    = 1'b0;
        res_nxt.rejected = 1'b1;
      end else begin
        line_nxt            = lr_pkg::line_advance(loaded);
        res_nxt.pixel_valid = 1'b1;
        res_nxt.pixel_x     = item.x0;
        res_nxt.pixel_y     = item.y0;
        res_nxt.pixel_color = item.c0;
      end
    end else if (line_r.busy) begin
      res_nxt.pixel_valid = 1'b1;
      if (lr_pkg::line_at_stop(line_r)) begin
        line_nxt.busy       = 1'b0;
        res_nxt.pixel_x     = line_r.stop_col;
        res_nxt.pixel_y     = line_r.stop_row;
        res_nxt.pixel_color = line_r.final_color;
        res_nxt.last_pixel  = 1'b1;
      end else begin
        line_nxt            = lr_pkg::line_advance(line_r);
        res_nxt.pixel_x     = line_r.cur_col;
        res_nxt.pixel_y     = line_r.cur_row;
        res_nxt.pixel_color = line_r.body_color;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_r <= '0;
    end else if (take) begin
      line_r <= line_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (core_ready) begin
      out_valid_r <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign res       = res_r;

`ifndef SYNTHESIS
  a_last_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
    (take && res_nxt.last_pixel) |=> !line_r.busy)
    else $error("line still busy after its last pixel");

  a_shallow_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (line_r.busy && !line_r.steep) |-> (line_r.cur_col <= line_r.stop_col))
    else $error("shallow line ran past its end column");

  a_rising_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (line_r.busy && line_r.steep && !line_r.rows_fall) |-> (line_r.cur_row <= line_r.stop_row))
    else $error("steep rising line ran past its end row");

  a_reject_no_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (res_r.rejected || res_r.last_pixel)) |->
      (res_r.rejected != res_r.pixel_valid))
    else $error("rejected result carries a pixel or last pixel lacks one");
`endif

endmodule

FILE: src/line_rasterizer_top.sv
// Top level of the Bresenham line rasterizer.
// The in_ channel takes one transaction per command. in_tuser is the action: a start
// transaction carries two endpoints and their colours in in_tdata, a step transaction asks
// for the next pixel of the current line. Every input transaction yields exactly one
// out_ transaction: a pixel (out_tuser[0] set), a rejection of an off-screen line
// (out_tuser[1] set) or an empty result for a step while no line is active. out_tlast
// marks the final endpoint pixel of a line.
// A transaction first passes the input register, where endpoints are ordered, checked
// against the screen and the deltas set up, and then the step logic, which writes the
// result register. One transaction is accepted every cycle while out_tready does not stall
// the result register; each step updates the decision term with a compare, an add and a subtract.
// When out_tready is low and a result is waiting, the result register holds. An empty
// input register still takes one further transaction; once it is full, in_tready stays
// low in the same cycle as out_tready until the result is taken.
// The user writes the screen size registers through cfg_we, cfg_addr and cfg_wdata while
// the block is idle; the block itself does not enforce this. Synchronous reset clears the
// line state, empties both registers and restores a 1024 by 768 screen.
module line_rasterizer_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [lr_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [lr_pkg::LIM_W-1:0]      cfg_wdata,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // start_x, start_y, end_x, end_y, start_color, end_color, zero fill
  input  logic [lr_pkg::IN_DATA_W-1:0]  in_tdata,
  // action
  input  logic                          in_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // pixel_x, pixel_y, pixel_color, zero fill
  output logic [lr_pkg::OUT_DATA_W-1:0] out_tdata,
  // pixel_valid, rejected
  output logic [lr_pkg::OUT_USER_W-1:0] out_tuser,
  output logic                          out_tlast
);

  logic          item_valid;
  lr_pkg::item_t item;
  logic          core_ready;
  lr_pkg::res_t  res;

  lr_prep u_prep (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .action      (in_tuser),
    .start_x     (in_tdata[12:0]),
    .start_y     (in_tdata[25:13]),
    .end_x       (in_tdata[38:26]),
    .end_y       (in_tdata[51:39]),
    .start_color (in_tdata[83:52]),
    .end_color   (in_tdata[115:84]),
    .item_valid  (item_valid),
    .item        (item),
    .core_ready  (core_ready)
  );

  lr_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .core_ready (core_ready),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .res        (res)
  );

  assign out_tdata = {2'b00, res.pixel_color, res.pixel_y, res.pixel_x};
  assign out_tuser = {res.rejected, res.pixel_valid};
  assign out_tlast = res.last_pixel;

endmodule

FILE: bench/line_rasterizer_top_test.sv
// Self-checking stream testbench for the line rasterizer, with its own Bresenham predictor.
`timescale 1ns / 1ps

module line_rasterizer_top_test;

  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 64;
  localparam int ITEM_TARGET = 1900;
  localparam int TAIL_ITEMS  = 250;

  localparam logic [lr_pkg::CFG_ADDR_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [lr_pkg::CFG_ADDR_W-1:0] REG_SPARE_3 = 2'd3;

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_we;
  logic [lr_pkg::CFG_ADDR_W-1:0] cfg_addr;
  logic [lr_pkg::LIM_W-1:0]      cfg_wdata;
  logic                          in_tvalid;
  logic                          in_tready;
  logic [lr_pkg::IN_DATA_W-1:0]  in_tdata;
  logic                          in_tuser;
  logic                          out_tvalid;
  logic                          out_tready;
  logic [lr_pkg::OUT_DATA_W-1:0] out_tdata;
  logic [lr_pkg::OUT_USER_W-1:0] out_tuser;
  logic                          out_tlast;

  line_rasterizer_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Predicted screen size and line state.
  lr_pkg::lim_t   scr_w;
  lr_pkg::lim_t   scr_h;
  logic           ln_busy;
  int             ln_col;
  int             ln_row;
  int             ln_stop_col;
  int             ln_stop_row;
  int             ln_err;
  int             ln_major;
  int             ln_minor;
  logic           ln_steep;
  logic           ln_fall;
  lr_pkg::color_t ln_body;
  lr_pkg::color_t ln_final;

  lr_pkg::res_t pending_pixels[$];
  int           items_sent;
  int           mismatches;
  int           quiet_cycles;
  bit           idle_en;
  bit           stall_en;
  bit           hold_off;
  bit           hold_done;

  function automatic int eff_dim(input lr_pkg::lim_t reg_val);
    return (reg_val > lr_pkg::MAX_SCREEN_DIM) ? lr_pkg::MAX_SCREEN_DIM : int'(reg_val);
  endfunction

  function automatic logic at_line_end();
    return ln_steep ? (ln_row == ln_stop_row) : (ln_col == ln_stop_col);
  endfunction

  function automatic void walk_line();
    int dir;
    dir = ln_fall ? -1 : 1;
    if (at_line_end()) begin
      return;
    end
    if (ln_err > 0) begin
      if (ln_steep) begin
        ln_col += 1;
      end else begin
        ln_row += dir;
      end
      ln_err -= 2 * ln_major;
    end
    ln_err += 2 * ln_minor;
    if (ln_steep) begin
      ln_row += dir;
    end else begin
      ln_col += 1;
    end
  endfunction

  function automatic lr_pkg::res_t plot_next(input logic act,
                                             input logic [lr_pkg::IN_DATA_W-1:0] d);
    lr_pkg::res_t      r;
    lr_pkg::in_coord_t ax, ay, bx, by;
    int                x0, y0, x1, y1, t, w, h, dx, dy, ady;
    lr_pkg::color_t    c0, c1, tc;
    r = '0;
    if (act == lr_pkg::ACT_START) begin
      ax = d[0 +: lr_pkg::IN_COORD_W];
      ay = d[13 +: lr_pkg::IN_COORD_W];
      bx = d[26 +: lr_pkg::IN_COORD_W];
      by = d[39 +: lr_pkg::IN_COORD_W];
      x0 = ax;
      y0 = ay;
      x1 = bx;
      y1 = by;
      c0 = d[52 +: lr_pkg::COLOR_W];
      c1 = d[84 +: lr_pkg::COLOR_W];
      if (x1 < x0) begin
        t = x0; x0 = x1; x1 = t;
        t = y0; y0 = y1; y1 = t;
        tc = c0; c0 = c1; c1 = tc;
      end
      w = eff_dim(scr_w);
      h = eff_dim(scr_h);
      if (x0 < 0 || x0 >= w || y0 < 0 || y0 >= h ||
          x1 < 0 || x1 >= w || y1 < 0 || y1 >= h) begin
        ln_busy = 1'b0;
        r.rejected = 1'b1;
        return r;
      end
      dx = x1 - x0;
      dy = y1 - y0;
      ady = (dy < 0) ? -dy : dy;
      ln_steep = !(dx > ady);
      ln_fall = !(dy > 0);
      ln_major = ln_steep ? ady : dx;
      ln_minor = ln_steep ? dx : ady;
      ln_err = 2 * ln_minor - ln_major;
      ln_col = x0;
      ln_row = y0;
      ln_stop_col = x1;
      ln_stop_row = y1;
      ln_body = c0;
      ln_final = c1;
      ln_busy = 1'b1;
      r.pixel_valid = 1'b1;
      r.pixel_x = lr_pkg::coord_t'(x0);
      r.pixel_y = lr_pkg::coord_t'(y0);
      r.pixel_color = c0;
      walk_line();
    end else if (ln_busy) begin
      r.pixel_valid = 1'b1;
      if (at_line_end()) begin
        r.pixel_x = lr_pkg::coord_t'(ln_stop_col);
        r.pixel_y = lr_pkg::coord_t'(ln_stop_row);
        r.pixel_color = ln_final;
        r.last_pixel = 1'b1;
        ln_busy = 1'b0;
      end else begin
        r.pixel_x = lr_pkg::coord_t'(ln_col);
        r.pixel_y = lr_pkg::coord_t'(ln_row);
        r.pixel_color = ln_body;
        walk_line();
      end
    end
    return r;
  endfunction

  function automatic logic [lr_pkg::IN_DATA_W-1:0] pack_line(input int x0, input int y0,
                                                             input int x1, input int y1,
                                                             input lr_pkg::color_t c0,
                                                             input lr_pkg::color_t c1);
    logic [lr_pkg::IN_DATA_W-1:0] d;
    d = '0;
    d[0 +: lr_pkg::IN_COORD_W]  = lr_pkg::in_coord_t'(x0);
    d[13 +: lr_pkg::IN_COORD_W] = lr_pkg::in_coord_t'(y0);
    d[26 +: lr_pkg::IN_COORD_W] = lr_pkg::in_coord_t'(x1);
    d[39 +: lr_pkg::IN_COORD_W] = lr_pkg::in_coord_t'(y1);
    d[52 +: lr_pkg::COLOR_W]    = c0;
    d[84 +: lr_pkg::COLOR_W]    = c1;
    return d;
  endfunction

  function automatic int clamp_dim(input int v, input int hi);
    return (v < 0) ? 0 : ((v > hi) ? hi : v);
  endfunction

  task automatic send_cmd(input logic act, input logic [lr_pkg::IN_DATA_W-1:0] d,
                          output lr_pkg::res_t r);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    r = plot_next(act, d);
    pending_pixels.push_back(r);
    items_sent++;
  endtask

  task automatic send_step(output lr_pkg::res_t r);
    logic [lr_pkg::IN_DATA_W-1:0] junk;
    junk = lr_pkg::IN_DATA_W'({$urandom, $urandom, $urandom, $urandom});
    send_cmd(lr_pkg::ACT_STEP, junk, r);
  endtask

  task automatic drain_pixels();
    in_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [lr_pkg::CFG_ADDR_W-1:0] idx, input lr_pkg::lim_t val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == lr_pkg::REG_SCREEN_WIDTH) begin
      scr_w = val;
    end else if (idx == lr_pkg::REG_SCREEN_HEIGHT) begin
      scr_h = val;
    end
  endtask

  task automatic set_screen(input lr_pkg::lim_t w, input lr_pkg::lim_t h);
    drain_pixels();
    cfg_write(lr_pkg::REG_SCREEN_WIDTH, w);
    cfg_write(lr_pkg::REG_SCREEN_HEIGHT, h);
  endtask

  task automatic draw_line(input int x0, input int y0, input int x1, input int y1,
                           input lr_pkg::color_t c0, input lr_pkg::color_t c1,
                           input int max_steps);
    lr_pkg::res_t r;
    int           n;
    n = 0;
    send_cmd(lr_pkg::ACT_START, pack_line(x0, y0, x1, y1, c0, c1), r);
    while (r.pixel_valid && !r.last_pixel && n < max_steps) begin
      send_step(r);
      n++;
    end
  endtask

  task automatic random_line(input int reach);
    int w, h, x0, y0, x1, y1, mode, limit, extra;
    w = eff_dim(scr_w);
    h = eff_dim(scr_h);
    if (w < 1) w = 1;
    if (h < 1) h = 1;
    mode = $urandom_range(0, 99);
    if (mode < 8) begin
      x0 = lr_pkg::in_coord_t'($urandom_range(0, 8191));
      y0 = lr_pkg::in_coord_t'($urandom_range(0, 8191));
      x1 = lr_pkg::in_coord_t'($urandom_range(0, 8191));
      y1 = lr_pkg::in_coord_t'($urandom_range(0, 8191));
    end else begin
      x0 = $urandom_range(0, w - 1);
      y0 = $urandom_range(0, h - 1);
      x1 = clamp_dim(x0 + $urandom_range(0, 2 * reach) - reach, w - 1);
      y1 = clamp_dim(y0 + $urandom_range(0, 2 * reach) - reach, h - 1);
      if (mode < 16) begin
        case ($urandom_range(0, 3))
          0: x0 = -$urandom_range(1, 3);
          1: x1 = w + $urandom_range(0, 2);
          2: y0 = -$urandom_range(1, 3);
          default: y1 = h + $urandom_range(0, 2);
        endcase
      end
    end
    limit = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 8) : 32'h7FFF_FFFF;
    draw_line(x0, y0, x1, y1, $urandom, $urandom, limit);
    if ($urandom_range(0, 9) == 0) begin
      extra = $urandom_range(1, 2);
      repeat (extra) begin
        lr_pkg::res_t r;
        send_step(r);
      end
    end
  endtask

  task automatic sweep_lines(input int count, input int reach);
    int stop_at;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      random_line(($urandom_range(0, 15) == 0) ? 8 * reach : reach);
    end
  endtask

  task automatic test_directed_lines();
    lr_pkg::res_t r;
    send_step(r);
    draw_line(1023, 767, 0, 0, 32'hFFFF_FFFF, 32'h0000_0000, 3);
    draw_line(5, 5, 5, 5, 32'h1234_5678, 32'h9ABC_DEF0, 4);
    send_step(r);
    draw_line(1024, 0, 0, 0, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 4);
    draw_line(0, -1, 3, 3, 32'h0000_0001, 32'h8000_0000, 4);
    draw_line(-4096, 4095, 4095, -4096, 32'hDEAD_BEEF, 32'hCAFE_F00D, 4);
    draw_line(10, 3, 7, 5, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 8);
    draw_line(2, 9, 4, 5, 32'h1111_1111, 32'h2222_2222, 8);
    draw_line(1, 1, 3, 1, 32'h3333_3333, 32'h4444_4444, 8);
    draw_line(6, 2, 6, 4, 32'h5555_5555, 32'h6666_6666, 8);
  endtask

  task automatic test_screen_sizes();
    set_screen(12'd2048, 12'd2048);
    draw_line(0, 2047, 2047, 0, $urandom, $urandom, 6);
    draw_line(3, 1000, 600, 700, $urandom, $urandom, 1000);
    sweep_lines(30, 12);
    set_screen(12'd4095, 12'd4095);
    draw_line(2047, 2047, 2047, 2040, $urandom, $urandom, 10);
    draw_line(2048, 0, 2047, 0, $urandom, $urandom, 4);
    sweep_lines(30, 12);
    set_screen(12'd1, 12'd1);
    draw_line(0, 0, 0, 0, $urandom, $urandom, 4);
    sweep_lines(15, 4);
    set_screen(12'd0, 12'd768);
    sweep_lines(15, 12);
    set_screen(12'd640, 12'd0);
    sweep_lines(15, 12);
    drain_pixels();
    cfg_write(REG_SPARE_2, lr_pkg::lim_t'($urandom));
    cfg_write(REG_SPARE_3, '1);
    sweep_lines(20, 12);
    set_screen(12'd17, 12'd2000);
    sweep_lines(30, 12);
  endtask

  task automatic test_back_pressure();
    set_screen(12'd1024, 12'd768);
    hold_off = 1'b1;
    sweep_lines(40, 20);
  endtask

  task automatic test_random_lines();
    int           pick;
    lr_pkg::lim_t w, h;
    while (items_sent < ITEM_TARGET - TAIL_ITEMS) begin
      pick = $urandom_range(0, 19);
      w = (pick == 0) ? lr_pkg::lim_t'(0) :
          (pick == 1) ? lr_pkg::lim_t'($urandom_range(2049, 4095)) :
          (pick == 2) ? lr_pkg::lim_t'($urandom_range(1, 4)) :
          lr_pkg::lim_t'($urandom_range(16, 2048));
      pick = $urandom_range(0, 19);
      h = (pick == 0) ? lr_pkg::lim_t'(0) :
          (pick == 1) ? lr_pkg::lim_t'($urandom_range(2049, 4095)) :
          (pick == 2) ? lr_pkg::lim_t'($urandom_range(1, 4)) :
          lr_pkg::lim_t'($urandom_range(16, 2048));
      set_screen(w, h);
      idle_en  = ($urandom_range(0, 3) != 0);
      stall_en = ($urandom_range(0, 3) != 0);
      sweep_lines(150, 12);
    end
  endtask

  task automatic test_steady_stream();
    set_screen(12'd2048, 12'd2048);
    idle_en  = 1'b0;
    stall_en = 1'b0;
    while (items_sent < ITEM_TARGET) begin
      random_line(12);
    end
  endtask

  // Receiver side: random back-pressure, and one long hold-off on request.
  initial begin
    out_tready <= 1'b1;
    forever begin
      @(posedge clk);
      if (hold_off && !hold_done) begin
        hold_done = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_tready <= 1'b1;
      end else if (stall_en && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_pixels
    lr_pkg::res_t got;
    lr_pkg::res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.pixel_valid = out_tuser[0];
      got.rejected    = out_tuser[1];
      got.pixel_x     = out_tdata[0 +: lr_pkg::COORD_W];
      got.pixel_y     = out_tdata[11 +: lr_pkg::COORD_W];
      got.pixel_color = out_tdata[22 +: lr_pkg::COLOR_W];
      got.last_pixel  = out_tlast;
      if (pending_pixels.size() == 0) begin
        if (mismatches < 10) begin
          $display("Unexpected result transaction: valid=%0b x=%0d y=%0d colour=%h",
                   got.pixel_valid, got.pixel_x, got.pixel_y, got.pixel_color);
        end
        mismatches++;
      end else begin
        want = pending_pixels.pop_front();
        if (got.pixel_valid !== want.pixel_valid || got.pixel_x !== want.pixel_x ||
            got.pixel_y !== want.pixel_y || got.pixel_color !== want.pixel_color ||
            got.last_pixel !== want.last_pixel || got.rejected !== want.rejected) begin
          if (mismatches < 10) begin
            $display("Mismatch at %0t: expected valid=%0b x=%0d y=%0d colour=%h last=%0b rej=%0b",
                     $realtime, want.pixel_valid, want.pixel_x, want.pixel_y,
                     want.pixel_color, want.last_pixel, want.rejected);
            $display("                 actual   valid=%0b x=%0d y=%0d colour=%h last=%0b rej=%0b",
                     got.pixel_valid, got.pixel_x, got.pixel_y, got.pixel_color,
                     got.last_pixel, got.rejected);
          end
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_addr  <= '0;
    cfg_wdata <= '0;
    in_tvalid <= 1'b0;
    in_tuser  <= lr_pkg::ACT_START;
    in_tdata  <= '0;
    scr_w = 12'd1024;
    scr_h = 12'd768;
    ln_busy = 1'b0;
    ln_col = 0;
    ln_row = 0;
    ln_stop_col = 0;
    ln_stop_row = 0;
    ln_err = 0;
    ln_major = 0;
    ln_minor = 0;
    ln_steep = 1'b0;
    ln_fall = 1'b0;
    ln_body = '0;
    ln_final = '0;
    items_sent = 0;
    idle_en = 1'b1;
    stall_en = 1'b1;
    hold_off = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_lines();
    test_screen_sizes();
    test_back_pressure();
    test_random_lines();
    test_steady_stream();

    drain_pixels();
    repeat (4) @(posedge clk);
    if (mismatches == 0 && pending_pixels.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: line_rasterizer_top.f
src/lr_pkg.sv
src/lr_prep.sv
src/lr_engine.sv
src/line_rasterizer_top.sv
bench/line_rasterizer_top_test.sv
